// File: hw/rtl/custom_alphabet_number_parser_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef CUSTOM_ALPHABET_NUMBER_PARSER_ASSERT_SVH
`define CUSTOM_ALPHABET_NUMBER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CABP_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cabp assertion failed");
// next-cycle implication
`define CABP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cabp assertion failed");
`else
`define CABP_ASSERT_NOW(label, clk, rst, cond, prop)
`define CABP_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// File: hw/rtl/cabp_pkg.sv
package cabp_pkg;

  localparam int unsigned ALPHA_SLOTS = 16;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned VALUE_W     = 32;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [1:0] REG_RADIX      = 2'd2;

  typedef enum logic [1:0] {
    PH_WS    = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  // alphabet status and digit lookup for the current char
  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] radix;
    logic               hit;
    logic [DIGIT_W-1:0] digit;
  } alpha_info_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
  endfunction

endpackage

// File: hw/rtl/cabp_alphabet.sv
module cabp_alphabet #(
  parameter int MAX_CHARS = 16
) (
  input  logic [127:0]               alphabet,
  input  logic [cabp_pkg::RADIX_W-1:0] radix_length,
  input  logic [7:0]                 char_code,
  output cabp_pkg::alpha_info_t      info
);

  logic [cabp_pkg::RADIX_W-1:0] radix_used;
  logic [MAX_CHARS-1:0]         in_use;
  logic [MAX_CHARS-1:0]         bad_char;
  logic [MAX_CHARS-1:0]         dup_char;
  logic [MAX_CHARS-1:0]         match;
  logic                         hit;
  logic [cabp_pkg::DIGIT_W-1:0] digit;

  assign radix_used = (radix_length > cabp_pkg::RADIX_W'(MAX_CHARS))
                    ? cabp_pkg::RADIX_W'(MAX_CHARS) : radix_length;

  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      in_use[i]   = cabp_pkg::RADIX_W'(i) < radix_used;
      bad_char[i] = in_use[i] && ((alphabet[8*i +: 8] == 8'h00)
                    || (alphabet[8*i +: 8] == cabp_pkg::CHAR_PLUS)
                    || (alphabet[8*i +: 8] == cabp_pkg::CHAR_MINUS)
                    || cabp_pkg::is_space(alphabet[8*i +: 8]));
      dup_char[i] = 1'b0;
      for (int j = i + 1; j < MAX_CHARS; j++) begin
        if (in_use[i] && (cabp_pkg::RADIX_W'(j) < radix_used)
            && (alphabet[8*i +: 8] == alphabet[8*j +: 8])) begin
          dup_char[i] = 1'b1;
        end
      end
      match[i] = in_use[i] && (alphabet[8*i +: 8] == char_code);
    end
  end

  // priority encode: lowest position wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit   = 1'b1;
        digit = cabp_pkg::DIGIT_W'(i);
      end
    end
  end

  always_comb begin
    info.ok    = (radix_used > cabp_pkg::RADIX_W'(1)) && !(|bad_char) && !(|dup_char);
    info.radix = radix_used;
    info.hit   = hit;
    info.digit = digit;
  end

endmodule

// File: hw/rtl/cabp_parse_core.sv
`include "custom_alphabet_number_parser_assert.svh"

module cabp_parse_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [7:0]                    char_code,
  input  logic                          present,
  input  logic                          last,
  input  cabp_pkg::alpha_info_t         info,
  output logic [cabp_pkg::VALUE_W-1:0]  result_value
);

  cabp_pkg::phase_t             phase, phase_next;
  logic                         neg, neg_next;
  logic [cabp_pkg::VALUE_W-1:0] acc, acc_next;
  cabp_pkg::phase_t             ph;
  logic                         n;
  logic [cabp_pkg::VALUE_W-1:0] a;
  logic [36:0]                  prod;

  assign prod = {5'b0, acc} * {32'b0, info.radix};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cabp_pkg::PH_WS;
      neg   <= 1'b0;
      acc   <= '0;
    end else if (step) begin
      phase <= phase_next;
      neg   <= neg_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    ph = phase;
    n  = neg;
    a  = acc;
    if (present) begin
      if (ph == cabp_pkg::PH_WS && !cabp_pkg::is_space(char_code)) begin
        ph = cabp_pkg::PH_SIGN;
      end
      if (ph == cabp_pkg::PH_SIGN) begin
        if (char_code == cabp_pkg::CHAR_MINUS) begin
          n = !n;
        end else if (char_code != cabp_pkg::CHAR_PLUS) begin
          ph = cabp_pkg::PH_DIGIT;
        end
      end
      if (ph == cabp_pkg::PH_DIGIT) begin
        if (!info.hit) begin
          ph = cabp_pkg::PH_STOP;
        end else begin
          a = prod[31:0] + {28'b0, info.digit};
        end
      end
    end
    result_value = info.ok ? (n ? (32'd0 - a) : a) : '0;
    // end of string returns to the idle state
    if (last) begin
      phase_next = cabp_pkg::PH_WS;
      neg_next   = 1'b0;
      acc_next   = '0;
    end else begin
      phase_next = ph;
      neg_next   = n;
      acc_next   = a;
    end
  end

  `CABP_ASSERT_NEXT(a_clear_after_last, clk, rst, step && last, (phase == cabp_pkg::PH_WS) && !neg && (acc == '0))
  `CABP_ASSERT_NEXT(a_stop_sticks, clk, rst, (phase == cabp_pkg::PH_STOP) && !(step && last), phase == cabp_pkg::PH_STOP)
  `CABP_ASSERT_NEXT(a_hold_when_idle, clk, rst, !step, $stable(acc) && $stable(neg))

endmodule

// File: hw/rtl/custom_alphabet_number_parser.sv
// Signed integer parser over a configurable digit alphabet. Bytes of a string
// arrive one item per cycle on the in channel while in_ready is high; the
// item with last set produces one result on the out channel: the signed
// value (wrapped to 32 bits), or 0 with alphabet_ok low if the alphabet is
// too short, holds a sign, whitespace, a zero byte, or a repeated char. Rate
// is one item per cycle sustained while results are taken. A result is
// presented in the cycle after its last item leaves the input register and
// loads the result register. The input stalls only while a last item waits
// behind a result not yet taken. The acc*radix+digit loop in the parse core
// sets that rate. Write alphabet_low/high and radix_length only while idle.
`include "custom_alphabet_number_parser_assert.svh"

module custom_alphabet_number_parser #(
  parameter int MAX_ALPHABET_CHARS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // config write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               present,
  input  logic               last,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] parsed_value,
  output logic               alphabet_ok
);

  // config registers
  logic [63:0]                  alphabet_low;
  logic [63:0]                  alphabet_high;
  logic [cabp_pkg::RADIX_W-1:0] radix_length;

  // input register
  logic       item_valid;
  logic [7:0] item_char;
  logic       item_present;
  logic       item_last;

  logic                         step;
  cabp_pkg::alpha_info_t        info;
  logic [cabp_pkg::VALUE_W-1:0] result_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
      radix_length  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cabp_pkg::REG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        cabp_pkg::REG_ALPHA_HIGH: alphabet_high <= cfg_data;
        cabp_pkg::REG_RADIX:      radix_length  <= cfg_data[cabp_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // An item leaves the input register whenever it gives no result, or the
  // result register is free or being drained this cycle.
  assign step     = item_valid && (!item_last || !out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_char    <= char_code;
      item_present <= present;
      item_last    <= last;
    end
  end

  cabp_alphabet #(
    .MAX_CHARS (MAX_ALPHABET_CHARS)
  ) u_alphabet (
    .alphabet     ({alphabet_high, alphabet_low}),
    .radix_length (radix_length),
    .char_code    (item_char),
    .info         (info)
  );

  cabp_parse_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .char_code    (item_char),
    .present      (item_present),
    .last         (item_last),
    .info         (info),
    .result_value (result_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && item_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item_last) begin
      parsed_value <= $signed(result_value);
      alphabet_ok  <= info.ok;
    end
  end

  `CABP_ASSERT_NOW(a_bad_alpha_zero, clk, rst, out_valid && !alphabet_ok, parsed_value == 32'sd0)
  `CABP_ASSERT_NOW(a_stall_needs_item, clk, rst, !in_ready, item_valid && item_last && out_valid && !out_ready)
  `CABP_ASSERT_NEXT(a_last_gives_result, clk, rst, step && item_last, out_valid)

endmodule

// File: tb/sv/custom_alphabet_number_parser_tb.sv
`timescale 1ns / 1ps

module custom_alphabet_number_parser_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD   = 6;   // result register path is two deep
  localparam int PHASE_ITEMS = 66;  // minimum items per random config phase
  localparam int RAND_PHASES = 9;

  typedef struct packed {
    logic [7:0] code;
    logic       present;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = cabp_pkg::REG_ALPHA_LOW;
  logic [63:0] cfg_data  = '0;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = '0;
  logic        present   = 1'b0;
  logic        last      = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] parsed_value;
  logic               alphabet_ok;

  custom_alphabet_number_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .present      (present),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .alphabet_ok  (alphabet_ok)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared state: pending input items, expected results, config shadow and the
  // parser state as the block should hold it.
  // ---------------------------------------------------------------------------
  char_item_t    char_q[$];
  parse_result_t expected_q[$];
  int            items_in_flight = 0;  // pushed, not yet accepted
  int            fail_count      = 0;
  int            cycle_count     = 0;
  bit            no_idle         = 1'b0;  // phases with back-to-back traffic

  logic [63:0] alpha_lo_sh  = '0;
  logic [63:0] alpha_hi_sh  = '0;
  logic [4:0]  radix_sh     = '0;

  cabp_pkg::phase_t parse_ph = cabp_pkg::PH_WS;
  logic        neg_sh       = 1'b0;
  logic [31:0] acc_sh       = '0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return (c >= cabp_pkg::CHAR_TAB && c <= cabp_pkg::CHAR_CR) || c == cabp_pkg::CHAR_SPACE;
  endfunction

  // radix register saturates at the alphabet size
  function automatic int radix_eff();
    return (radix_sh > cabp_pkg::ALPHA_SLOTS) ? int'(cabp_pkg::ALPHA_SLOTS) : int'(radix_sh);
  endfunction

  function automatic logic [7:0] alpha_char(input int i);
    return (i < 8) ? alpha_lo_sh[8*i +: 8] : alpha_hi_sh[8*(i-8) +: 8];
  endfunction

  function automatic logic alphabet_valid();
    int n;
    logic [7:0] c;
    n = radix_eff();
    if (n <= 1) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = alpha_char(i);
      if (c == 8'h00 || c == cabp_pkg::CHAR_PLUS || c == cabp_pkg::CHAR_MINUS || is_blank(c))
        return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (alpha_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // first position of c in the alphabet, -1 if absent
  function automatic int digit_of(input logic [7:0] c);
    for (int i = 0; i < radix_eff(); i++)
      if (alpha_char(i) == c) return i;
    return -1;
  endfunction

  // Advances the expected parser state by one accepted item; on last it
  // queues the expected result and clears the state for the next string.
  function automatic void parse_step(input char_item_t it);
    int d;
    parse_result_t res;
    if (it.present) begin
      if (parse_ph == cabp_pkg::PH_WS && !is_blank(it.code)) parse_ph = cabp_pkg::PH_SIGN;
      if (parse_ph == cabp_pkg::PH_SIGN) begin
        if (it.code == cabp_pkg::CHAR_MINUS) neg_sh = ~neg_sh;
        else if (it.code != cabp_pkg::CHAR_PLUS) parse_ph = cabp_pkg::PH_DIGIT;
      end
      if (parse_ph == cabp_pkg::PH_DIGIT) begin
        d = digit_of(it.code);
        if (d < 0) parse_ph = cabp_pkg::PH_STOP;
        else acc_sh = acc_sh * 32'(radix_eff()) + 32'(d);
      end
    end
    if (it.last) begin
      res.ok    = alphabet_valid();
      res.value = !res.ok ? 32'sd0 : (neg_sh ? -$signed(acc_sh) : $signed(acc_sh));
      expected_q.push_back(res);
      parse_ph = cabp_pkg::PH_WS;
      neg_sh   = 1'b0;
      acc_sh   = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending items, holds each until accepted, random gaps after.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    char_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_step('{code: char_code, present: present, last: last});
        items_in_flight--;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          nxt = char_q.pop_front();
          in_valid  <= 1'b1;
          char_code <= nxt.code;
          present   <= nxt.present;
          last      <= nxt.last;
          send_gap = no_idle ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls on out_ready, check against oldest expectation.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: value %0d ok %0b",
                                    parsed_value, alphabet_ok));
        end else begin
          want = expected_q.pop_front();
          if (parsed_value !== want.value)
            report_mismatch($sformatf("parsed_value %0d, expected %0d",
                                      parsed_value, want.value));
          if (alphabet_ok !== want.ok)
            report_mismatch($sformatf("alphabet_ok %0b, expected %0b",
                                      alphabet_ok, want.ok));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) stall_left = gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic [7:0] c, input logic p, input logic l);
    char_q.push_back('{code: c, present: p, last: l});
    items_in_flight++;
  endtask

  // Text bytes, last flag on the final byte or on a separate end marker.
  // Empty items get sprinkled in now and then.
  task automatic add_string(input logic [7:0] text[$], input bit end_marker);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 11) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_item(text[i], 1'b1, !end_marker && i == text.size() - 1);
    end
    if (end_marker || text.size() == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Waits until every pushed item went in and every result came out, then
  // pads past the pipeline since non-last items leave nothing to wait on.
  task automatic wait_drained();
    while (items_in_flight != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while drained.
  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] rad);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= cabp_pkg::REG_ALPHA_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= cabp_pkg::REG_ALPHA_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= cabp_pkg::REG_RADIX;
    cfg_data  <= {$urandom, $urandom} & ~64'h1F | 64'(rad);  // upper bits junk
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= {$urandom, $urandom};
    alpha_lo_sh = lo;
    alpha_hi_sh = hi;
    radix_sh    = rad;
  endtask

  // Random alphabet of distinct legal chars, sometimes broken on purpose.
  task automatic random_config();
    logic [7:0] slot[16];
    logic [63:0] lo, hi;
    logic [4:0] rad;
    int n, r, i, j;
    bit clash;
    r = $urandom_range(0, 19);
    if (r == 0) rad = 5'd0;
    else if (r == 1) rad = 5'd1;
    else if (r == 2) rad = 5'd2;
    else if (r < 5) rad = 5'd16;
    else if (r == 5) rad = 5'($urandom_range(17, 31));
    else rad = 5'($urandom_range(2, 16));
    for (i = 0; i < 16; i++) begin
      do begin
        slot[i] = 8'($urandom_range(1, 255));
        clash = is_blank(slot[i]) || slot[i] == cabp_pkg::CHAR_PLUS
                || slot[i] == cabp_pkg::CHAR_MINUS;
        for (j = 0; j < i; j++) if (slot[j] == slot[i]) clash = 1'b1;
      end while (clash);
    end
    n = (rad > 16) ? 16 : int'(rad);
    if (n >= 2) begin
      i = $urandom_range(0, n - 2);
      j = $urandom_range(i + 1, n - 1);
      case ($urandom_range(0, 9))
        0: slot[j] = slot[i];                                   // duplicate
        1: slot[j] = $urandom_range(0, 1) ? cabp_pkg::CHAR_PLUS : cabp_pkg::CHAR_MINUS;
        2: slot[j] = $urandom_range(0, 5) == 0
                   ? cabp_pkg::CHAR_SPACE
                   : 8'(cabp_pkg::CHAR_TAB + $urandom_range(0, 4));
        3: slot[j] = 8'h00;                                     // zero byte
        default: ;
      endcase
    end
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = slot[i];
      hi[8*i +: 8] = slot[i+8];
    end
    load_config(lo, hi, rad);
  endtask

  // Mostly well-formed: whitespace, signs, alphabet digits, optional junk
  // tail. One in ten is plain random bytes.
  task automatic add_random_string(output int n_items);
    logic [7:0] text[$];
    int n;
    n = radix_eff();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3))
        text.push_back($urandom_range(0, 5) == 0
                       ? cabp_pkg::CHAR_SPACE
                       : 8'(cabp_pkg::CHAR_TAB + $urandom_range(0, 4)));
      repeat ($urandom_range(0, 3))
        text.push_back($urandom_range(0, 1) ? cabp_pkg::CHAR_MINUS : cabp_pkg::CHAR_PLUS);
      repeat ($urandom_range(0, 12))
        text.push_back(n > 0 ? alpha_char($urandom_range(0, n - 1))
                             : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 4)
        repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
    end
    add_string(text, $urandom_range(0, 3) == 0);
    n_items = text.size() + 1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed strings, random config phases, final check.
  // ---------------------------------------------------------------------------
  initial begin
    int phase_items, got;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset alphabet is empty, so anything parses to zero with ok low
    add_string('{cabp_pkg::CHAR_SPACE, "5"}, 1'b0);
    wait_drained();

    // decimal; bytes above the radix are ignored
    load_config("76543210", "fedcba98", 5'd10);
    // whitespace run, two minus signs cancel, stop char, bytes after the stop
    add_string('{cabp_pkg::CHAR_TAB, cabp_pkg::CHAR_CR, cabp_pkg::CHAR_SPACE,
                 cabp_pkg::CHAR_MINUS, cabp_pkg::CHAR_PLUS, cabp_pkg::CHAR_MINUS,
                 "4", "2", "x", "7"}, 1'b0);
    // zero byte stops the parse; top byte value after it
    add_string('{"9", 8'h00, 8'hFF}, 1'b0);
    // empty item then a bare end marker
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    // hex with oversize radix register, saturates to 16; wraps to min int
    load_config("76543210", "fedcba98", 5'd31);
    add_string('{cabp_pkg::CHAR_MINUS, "8", "0", "0", "0", "0", "0", "0", "0"}, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      no_idle = (ph % 4 == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        add_random_string(got);
        phase_items += got;
      end
      // every phase ends with a full drain before the next config write
      wait_drained();
    end
    no_idle = 1'b0;

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cabp_pkg.sv
hw/rtl/cabp_alphabet.sv
hw/rtl/cabp_parse_core.sv
hw/rtl/custom_alphabet_number_parser.sv
tb/sv/custom_alphabet_number_parser_tb.sv
